// ===== src/multichannel_scalar_kalman_defines.svh =====
// assertion macros for the scalar kalman filter checker
`ifndef MULTICHANNEL_SCALAR_KALMAN_DEFINES_SVH
`define MULTICHANNEL_SCALAR_KALMAN_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define MSKF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mskf assertion failed");

// consequent checked in the same cycle as the antecedent
`define MSKF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mskf assertion failed");

`endif

// ===== src/mskf_pkg.sv =====
// types, constants, noise tables and microprogram of the scalar kalman filter
`timescale 1ns / 1ps

package mskf_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = 4;
  localparam int DATA_W   = 16;
  localparam int EST_W    = 7;
  localparam int COV_W    = 20;
  localparam int GAIN_W   = 16;
  localparam int DIV_W    = COV_W + 1;
  localparam int CNT_W    = 4;
  localparam int PC_W     = 3;

  localparam logic [COV_W-1:0] COV_MAX = 20'hFFFFF;
  localparam logic [COV_W-1:0] COV_ONE = 20'h10000;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_PRED,
    OP_DINIT,
    OP_DSTEP,
    OP_MULK,
    OP_MULP,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_HOLD_IN,
    JMP_HOLD_OUT
  } jmp_t;

  typedef struct packed {
    op_t  op;
    jmp_t jmp;
    pc_t  target;
  } ctrl_t;

  localparam pc_t PC_START = 3'd0;
  localparam pc_t PC_DSTEP = 3'd3;

  // microprogram: one control word per step
  function automatic ctrl_t prog_word(input pc_t pc);
    ctrl_t w;
    w = '{op: OP_WAIT, jmp: JMP_HOLD_IN, target: PC_START};
    unique case (pc)
      3'd0:    w = '{op: OP_WAIT,  jmp: JMP_HOLD_IN,  target: PC_START};
      3'd1:    w = '{op: OP_PRED,  jmp: JMP_NEXT,     target: PC_START};
      3'd2:    w = '{op: OP_DINIT, jmp: JMP_NEXT,     target: PC_START};
      3'd3:    w = '{op: OP_DSTEP, jmp: JMP_LOOP,     target: PC_DSTEP};
      3'd4:    w = '{op: OP_MULK,  jmp: JMP_NEXT,     target: PC_START};
      3'd5:    w = '{op: OP_MULP,  jmp: JMP_NEXT,     target: PC_START};
      3'd6:    w = '{op: OP_DONE,  jmp: JMP_HOLD_OUT, target: PC_START};
      default: w = '{op: OP_WAIT,  jmp: JMP_HOLD_IN,  target: PC_START};
    endcase
    return w;
  endfunction

  // process noise per channel, unsigned q4.16
  function automatic logic [COV_W-1:0] proc_noise(input logic [CH_W-1:0] ch);
    logic [COV_W-1:0] v;
    v = '0;
    unique case (ch)
      4'd0:  v = 20'd38011;
      4'd1:  v = 20'd39322;
      4'd2:  v = 20'd41288;
      4'd3:  v = 20'd34734;
      4'd4:  v = 20'd33423;
      4'd5:  v = 20'd34734;
      4'd6:  v = 20'd32768;
      4'd7:  v = 20'd34079;
      4'd8:  v = 20'd34079;
      4'd9:  v = 20'd32768;
      4'd10: v = 20'd34734;
      4'd11: v = 20'd32113;
      4'd12: v = 20'd37356;
      4'd13: v = 20'd35389;
      4'd14: v = 20'd32768;
      4'd15: v = 20'd33423;
    endcase
    return v;
  endfunction

  // observation noise per channel, unsigned q4.16, never zero
  function automatic logic [COV_W-1:0] obs_noise(input logic [CH_W-1:0] ch);
    logic [COV_W-1:0] v;
    v = '0;
    unique case (ch)
      4'd0:  v = 20'd183501;
      4'd1:  v = 20'd227410;
      4'd2:  v = 20'd173015;
      4'd3:  v = 20'd145490;
      4'd4:  v = 20'd39322;
      4'd5:  v = 20'd24248;
      4'd6:  v = 20'd30147;
      4'd7:  v = 20'd37356;
      4'd8:  v = 20'd30802;
      4'd9:  v = 20'd13107;
      4'd10: v = 20'd164495;
      4'd11: v = 20'd222822;
      4'd12: v = 20'd205128;
      4'd13: v = 20'd105513;
      4'd14: v = 20'd13763;
      4'd15: v = 20'd9830;
    endcase
    return v;
  endfunction

endpackage

// ===== src/multichannel_scalar_kalman.sv =====
// top level of the 16-channel scalar kalman filter, microcoded sequencer and datapath
`timescale 1ns / 1ps

// usage
//   input channel: in_valid / in_stall with in_channel, in_measurement and
//   in_prior_estimate (signed q8.8). a beat is taken when in_valid is high
//   and in_stall is low.
//   result channel: out_valid / out_stall with out_estimate, the integer part
//   of the corrected estimate (negatives give 0). one result beat per input.
//   the item passes through one step each for prediction and divider setup,
//   the 16 steps of the restoring divider that forms the gain, one step
//   each for the two multiplies, and the write-back step, which registers
//   the result. the next input beat is taken only once the sequencer is
//   back at its wait step.
//   in_stall is high from the cycle after an input beat until the sequencer
//   returns to its wait step.
//   a stalled result stays in the output register; the next item is still
//   taken and worked on, and its write-back step waits until the register
//   is free.
//   reset (rst_n low, synchronous) sets every channel's covariance to 1.0,
//   empties the output register and returns the sequencer to its wait step.
module multichannel_scalar_kalman (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [mskf_pkg::CH_W-1:0]      in_channel,
  input  logic signed [mskf_pkg::DATA_W-1:0]    in_measurement,
  input  logic signed [mskf_pkg::DATA_W-1:0]    in_prior_estimate,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [mskf_pkg::EST_W-1:0]     out_estimate
);
  import mskf_pkg::*;

  // sequencer
  pc_t   pc_r, pc_nxt;
  ctrl_t cw;

  // per-channel covariance, unsigned q4.16
  logic [COV_W-1:0] cov_r [CHANNELS];

  // item registers
  logic [CH_W-1:0]          ch_r;
  logic signed [DATA_W-1:0] z_r;
  logic signed [DATA_W-1:0] x_r;

  // datapath registers
  logic [COV_W-1:0]  pt_r;       // predicted covariance
  logic [DATA_W-1:0] mag_r;      // |z - x|
  logic              neg_r;      // z < x
  logic [DIV_W-1:0]  rem_r;      // divider partial remainder
  logic [DIV_W-1:0]  div_r;      // divisor pt + r
  logic [GAIN_W-1:0] quot_r;     // gain, q0.16
  logic [CNT_W-1:0]  cnt_r;      // divider step count
  logic [DATA_W-1:0] corr_r;     // correction magnitude
  logic [COV_W-1:0]  covn_r;     // new covariance

  logic             out_valid_r;
  logic [EST_W-1:0] out_est_r;

  // combinational helpers
  logic                     ch_ok;
  logic                     out_free;
  logic                     done_fire;
  logic [DIV_W-1:0]         pred_sum;
  logic [COV_W-1:0]         pred_pt;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W:0]   diff_abs;
  logic [DIV_W:0]           rem_sh;
  logic                     qbit;
  logic [2*DATA_W-1:0]      prod_k;
  logic [COV_W:0]           one_minus_k;
  logic [COV_W+COV_W:0]     prod_p;
  logic signed [DATA_W+1:0] est_full;
  logic [EST_W-1:0]         est_clamped;

  assign cw = prog_word(pc_r);

  assign ch_ok     = (32'(ch_r) < CHANNELS);
  assign out_free  = !out_valid_r || !out_stall;
  assign done_fire = (cw.op == OP_DONE) && out_free;

  assign in_stall     = (cw.op != OP_WAIT);
  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;

  // prediction: covariance plus process noise, saturated; difference z - x and its magnitude
  always_comb begin
    pred_sum = {1'b0, cov_r[ch_r]} + {1'b0, proc_noise(ch_r)};
    pred_pt  = pred_sum[COV_W] ? COV_MAX : pred_sum[COV_W-1:0];
    diff     = {z_r[DATA_W-1], z_r} - {x_r[DATA_W-1], x_r};
    diff_abs = diff[DATA_W] ? -diff : diff;
  end

  // one restoring division step
  always_comb begin
    rem_sh = {rem_r, 1'b0};
    qbit   = (rem_sh >= {1'b0, div_r});
  end

  // multiplies and corrected estimate
  always_comb begin
    prod_k      = {{DATA_W{1'b0}}, quot_r} * {{DATA_W{1'b0}}, mag_r};
    one_minus_k = {1'b0, COV_ONE} - {{(COV_W+1-GAIN_W){1'b0}}, quot_r};
    prod_p      = {{COV_W{1'b0}}, one_minus_k} * {{(COV_W+1){1'b0}}, pt_r};
    est_full    = neg_r
                  ? ({{2{x_r[DATA_W-1]}}, x_r} - {2'b00, corr_r})
                  : ({{2{x_r[DATA_W-1]}}, x_r} + {2'b00, corr_r});
    est_clamped = est_full[DATA_W+1] ? '0 : est_full[8 +: EST_W];
  end

  // next step of the microprogram
  always_comb begin
    pc_nxt = pc_r;
    unique case (cw.jmp)
      JMP_NEXT:     pc_nxt = pc_r + 1'b1;
      JMP_LOOP:     pc_nxt = (cnt_r != '0) ? cw.target : pc_r + 1'b1;
      JMP_HOLD_IN:  pc_nxt = in_valid ? pc_r + 1'b1 : pc_r;
      JMP_HOLD_OUT: pc_nxt = out_free ? cw.target : pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_START;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // covariance store, reset to 1.0 in every channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cov_r[i] <= COV_ONE;
      end
    end else if (done_fire && ch_ok) begin
      cov_r[ch_r] <= covn_r;
    end
  end

  // datapath driven by the control word
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_WAIT: begin
        if (in_valid) begin
          ch_r <= in_channel;
          z_r  <= in_measurement;
          x_r  <= in_prior_estimate;
        end
      end
      OP_PRED: begin
        pt_r  <= pred_pt;
        neg_r <= diff[DATA_W];
        mag_r <= diff_abs[DATA_W-1:0];
      end
      OP_DINIT: begin
        rem_r <= {1'b0, pt_r};
        div_r <= {1'b0, pt_r} + {1'b0, obs_noise(ch_r)};
        cnt_r <= CNT_W'(GAIN_W - 1);
      end
      OP_DSTEP: begin
        rem_r  <= qbit ? DIV_W'(rem_sh - {1'b0, div_r}) : rem_sh[DIV_W-1:0];
        quot_r <= {quot_r[GAIN_W-2:0], qbit};
        cnt_r  <= cnt_r - 1'b1;
      end
      OP_MULK: begin
        corr_r <= prod_k[2*DATA_W-1:DATA_W];
      end
      OP_MULP: begin
        covn_r <= prod_p[GAIN_W +: COV_W];
      end
      OP_DONE: begin
        if (done_fire) begin
          out_est_r <= ch_ok ? est_clamped : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== src/mskf_checker.sv =====
// port-level checker for the scalar kalman filter and its bind
`timescale 1ns / 1ps
`include "multichannel_scalar_kalman_defines.svh"

module mskf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_estimate
);

  // a stalled result beat stays
  `MSKF_ASSERT_NXT(a_out_valid_hold, out_valid && out_stall, out_valid)

  // a stalled result beat keeps its value
  `MSKF_ASSERT_NXT(a_out_data_hold, out_valid && out_stall, $stable(out_estimate))

  // the block is busy right after taking an input beat
  `MSKF_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall)

  // a new result only appears at the end of an item in flight
  `MSKF_ASSERT_NOW(a_result_from_item, $rose(out_valid), $past(in_stall))

endmodule

bind multichannel_scalar_kalman mskf_checker u_mskf_checker (.*);

// ===== sim/testbench.sv =====
// testbench for the 16-channel scalar kalman filter: directed table, random readings, gain predictor
`timescale 1ns / 1ps

module testbench;
  import mskf_pkg::*;

  localparam int N_DIRECTED  = 20;
  localparam int N_RANDOM    = 1880;
  localparam int SHOW_ERRORS = 10;
  localparam int DRAIN_WAIT  = 40;   // cycles after the last result
  localparam int HOLD_CYCLES = 600;  // one long receiver hold-off
  localparam int HOLD_AFTER  = 300;  // results seen before the hold-off starts

  // per-channel noise constants, unsigned q4.16
  localparam logic [COV_W-1:0] QN_TABLE [16] = '{
    20'd38011, 20'd39322, 20'd41288, 20'd34734, 20'd33423, 20'd34734, 20'd32768, 20'd34079,
    20'd34079, 20'd32768, 20'd34734, 20'd32113, 20'd37356, 20'd35389, 20'd32768, 20'd33423
  };
  localparam logic [COV_W-1:0] RN_TABLE [16] = '{
    20'd183501, 20'd227410, 20'd173015, 20'd145490, 20'd39322, 20'd24248, 20'd30147,
    20'd37356, 20'd30802, 20'd13107, 20'd164495, 20'd222822, 20'd205128, 20'd105513,
    20'd13763, 20'd9830
  };

  // one row of the directed table; est is used only where known is set
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] x;
    logic              known;
    logic [EST_W-1:0]  est;
  } reading_row_t;

  localparam reading_row_t DIRECTED [N_DIRECTED] = '{
    '{4'd0,  16'd0,     16'd0,     1'b1, 7'd0},    // all zero
    '{4'd15, 16'h7FFF,  16'h7FFF,  1'b1, 7'd127},  // largest estimate
    '{4'd1,  16'h8000,  16'h8000,  1'b1, 7'd0},    // most negative, clamped
    '{4'd2,  16'h0100,  16'h0100,  1'b1, 7'd1},    // exactly 1.0
    '{4'd3,  16'hFFFF,  16'hFFFF,  1'b1, 7'd0},    // just below zero, clamped
    '{4'd6,  16'h00FF,  16'h00FF,  1'b1, 7'd0},    // fraction truncated away
    '{4'd9,  16'h6400,  16'h6400,  1'b1, 7'd100},
    '{4'd4,  16'h7FFF,  16'h8000,  1'b0, 7'd0},    // largest upward step
    '{4'd5,  16'h8000,  16'h7FFF,  1'b0, 7'd0},    // largest downward step
    '{4'd7,  16'h3200,  16'h0000,  1'b0, 7'd0},
    '{4'd8,  16'h0000,  16'h3200,  1'b0, 7'd0},
    '{4'd10, 16'hF600,  16'h0A00,  1'b0, 7'd0},    // crosses zero downward
    '{4'd11, 16'h0A00,  16'hF600,  1'b0, 7'd0},    // crosses zero upward
    '{4'd12, 16'h7FFF,  16'h0000,  1'b0, 7'd0},
    '{4'd13, 16'h8000,  16'h0000,  1'b0, 7'd0},
    '{4'd14, 16'd5000,  16'd4000,  1'b0, 7'd0},    // same channel again and again,
    '{4'd14, 16'd5000,  16'd4000,  1'b0, 7'd0},    // covariance shrinks each time
    '{4'd14, 16'd5000,  16'd4000,  1'b0, 7'd0},
    '{4'd0,  16'h7FFF,  16'h7FFF,  1'b1, 7'd127},
    '{4'd15, 16'h8000,  16'h7FFF,  1'b0, 7'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CH_W-1:0]          in_channel = '0;
  logic signed [DATA_W-1:0] in_measurement = '0;
  logic signed [DATA_W-1:0] in_prior_estimate = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [EST_W-1:0]         out_estimate;

  // predictor state: covariance per channel, q4.16
  logic [COV_W-1:0] chan_cov [CHANNELS];
  logic [EST_W-1:0] pending_est [$];
  int               error_count  = 0;
  int               results_seen = 0;

  always #2 clk = ~clk;

  multichannel_scalar_kalman u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel        (in_channel),
    .in_measurement    (in_measurement),
    .in_prior_estimate (in_prior_estimate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_estimate      (out_estimate)
  );

  // one filter update: predict covariance, form the gain, correct the estimate,
  // write back the shrunk covariance and return the clamped integer part
  function automatic logic [EST_W-1:0] kalman_update(input logic [CH_W-1:0] ch,
                                                     input logic signed [DATA_W-1:0] z,
                                                     input logic signed [DATA_W-1:0] x);
    longint unsigned pt, gain, mag, corr;
    int              diff, est;
    if (int'(ch) >= CHANNELS) return '0;
    pt = longint'(chan_cov[ch]) + longint'(QN_TABLE[ch]);
    if (pt > longint'(COV_MAX)) pt = longint'(COV_MAX);
    gain = (pt << 16) / (pt + longint'(RN_TABLE[ch]));
    if (gain > (64'd1 << GAIN_W) - 1) gain = (64'd1 << GAIN_W) - 1;
    diff = int'(z) - int'(x);
    mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
    // correction rounds toward zero
    corr = (gain * mag) >> 16;
    est  = (diff < 0) ? int'(x) - int'(corr) : int'(x) + int'(corr);
    chan_cov[ch] = COV_W'(((longint'(COV_ONE) - gain) * pt) >> 16);
    if (est < 0) return '0;
    return EST_W'(est >>> 8);
  endfunction

  // random reading: mostly a tracking measurement close to the prior,
  // else full-range noise or field extremes
  task automatic make_reading(inout logic [CH_W-1:0] ch,
                              output logic signed [DATA_W-1:0] z,
                              output logic signed [DATA_W-1:0] x);
    int kind, xi, zi;
    int corner [5] = '{-32768, -1, 0, 1, 32767};
    // half the time the channel is kept, so covariance walks down
    if ($urandom_range(1) == 0) ch = CH_W'($urandom_range(CHANNELS - 1));
    kind = $urandom_range(99);
    if (kind < 60) begin
      xi = int'($urandom_range(34815)) - 2048;
      zi = xi + int'($urandom_range(2047)) - 1024;
      if (zi > 32767) zi = 32767;
      if (zi < -32768) zi = -32768;
    end else if (kind < 85) begin
      xi = int'($urandom_range(65535)) - 32768;
      zi = int'($urandom_range(65535)) - 32768;
    end else begin
      xi = corner[$urandom_range(4)];
      zi = corner[$urandom_range(4)];
    end
    z = DATA_W'(zi);
    x = DATA_W'(xi);
  endtask

  // sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(6, 1);
    if (r < 97) return $urandom_range(40, 7);
    return $urandom_range(300, 41);
  endfunction

  // offer one beat and hold it until taken; the expectation is booked at the
  // accepting edge, using the typed value where the table gives one
  task automatic offer_reading(input logic [CH_W-1:0] ch,
                               input logic signed [DATA_W-1:0] z,
                               input logic signed [DATA_W-1:0] x,
                               input logic known,
                               input logic [EST_W-1:0] typed_est,
                               input int gap);
    logic [EST_W-1:0] predicted;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_channel        <= ch;
    in_measurement    <= z;
    in_prior_estimate <= x;
    do @(posedge clk); while (in_stall);
    predicted = kalman_update(ch, z, x);
    pending_est.push_back(known ? typed_est : predicted);
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    error_count++;
    if (error_count <= SHOW_ERRORS)
      $display("%t estimate mismatch (%s): expected %0d got %0d", $realtime, what, want, got);
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    logic [EST_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_est.size() == 0) begin
        note_mismatch("no beat pending", -1, int'(out_estimate));
      end else begin
        want = pending_est.pop_front();
        if (out_estimate !== want) note_mismatch("estimate", int'(want), int'(out_estimate));
      end
    end
  end

  // receiver: random stall segments, quiet stretches, and one long hold-off
  // while the sender keeps offering so the block backs up into in_stall
  initial begin : result_sink
    logic seg_stall;
    int   seg_len, r;
    bit   hold_done;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        seg_stall = 1'b1;
        seg_len   = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        seg_stall = 1'b0;
        seg_len   = $urandom_range(200, 20);
      end else begin
        seg_stall = ($urandom_range(99) < 40);
        r = $urandom_range(99);
        if (!seg_stall) seg_len = $urandom_range(30, 1);
        else if (r < 60) seg_len = $urandom_range(4, 1);
        else if (r < 90) seg_len = $urandom_range(40, 5);
        else seg_len = $urandom_range(250, 41);
      end
      @(negedge clk);
      out_stall <= seg_stall;
      repeat (seg_len - 1) @(negedge clk);
    end
  end

  // main sequence: reset, directed table, random readings, drain, verdict
  initial begin : stimulus
    logic [CH_W-1:0]          ch;
    logic signed [DATA_W-1:0] z, x;
    bit                       quiet;
    for (int c = 0; c < CHANNELS; c++) chan_cov[c] = COV_ONE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      offer_reading(DIRECTED[i].ch, DIRECTED[i].z, DIRECTED[i].x,
                    DIRECTED[i].known, DIRECTED[i].est, (i % 3 == 0) ? 0 : pick_gap());

    ch    = '0;
    quiet = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      // switch between back-to-back stretches and gappy ones
      if (n % 64 == 0) quiet = ($urandom_range(3) == 0);
      make_reading(ch, z, x);
      offer_reading(ch, z, x, 1'b0, '0, quiet ? 0 : pick_gap());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_est.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin : watchdog
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule
